// ----- rtl/bcrm_pkg.sv -----
// bcrm_pkg: opcodes, decode phases, event codes and the command word
// passed from the decoder to the execute unit. No dependencies.
package bcrm_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned RegAddrW = $clog2(NumRegs);
  localparam int unsigned DataW    = 64;
  localparam int unsigned PosW     = 16;
  localparam int unsigned QueueDepth = 4;

  // Opcode bytes
  localparam logic [7:0] OpHalt = 8'h00;
  localparam logic [7:0] OpMov  = 8'h01;
  localparam logic [7:0] OpAdd  = 8'h02;
  localparam logic [7:0] OpOut  = 8'h07;
  localparam logic [7:0] OpSys  = 8'h0F;

  // Decode phases
  localparam logic [3:0] PhOpcode   = 4'd0;
  localparam logic [3:0] PhOperand  = 4'd1;
  localparam logic [3:0] PhSecond   = 4'd2;
  localparam logic [3:0] PhImmLast  = 4'd9;

  // Event kinds on the result channel
  localparam logic [1:0] EvOut     = 2'd0;
  localparam logic [1:0] EvSys     = 2'd1;
  localparam logic [1:0] EvHalt    = 2'd2;
  localparam logic [1:0] EvUnknown = 2'd3;

  // Instruction in decode
  typedef enum logic [2:0] {
    OPC_NONE = 3'd0,
    OPC_MOV  = 3'd1,
    OPC_ADD  = 3'd2,
    OPC_OUT  = 3'd3,
    OPC_SYS  = 3'd4
  } opc_e;

  // Completed command for the execute unit
  typedef enum logic [2:0] {
    CMD_MOV  = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_OUT  = 3'd2,
    CMD_SYS  = 3'd3,
    CMD_HALT = 3'd4,
    CMD_UNK  = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [RegAddrW-1:0] ra;    // MOV/ADD destination
    logic [RegAddrW-1:0] rb;    // ADD source, OUT register
    logic [7:0]          code;  // OUT port, SYS id, unknown opcode
    logic [PosW-1:0]     pos;   // HALT/unknown stop position
    logic [DataW-1:0]    imm;   // MOV immediate
  } cmd_t;

endpackage

// ----- rtl/bcrm_if.sv -----
// bcrm_if: stream interfaces for program bytes in and events out.
// Depends on nothing; widths follow the block's fixed field widths.
interface bcrm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output code_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input code_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface bcrm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  port_number;
  logic [63:0] port_value;
  logic [7:0]  code_value;
  logic [15:0] byte_position;

  modport source (output valid, output event_kind, output port_number, output port_value,
                  output code_value, output byte_position, input ready);
  modport sink   (input valid, input event_kind, input port_number, input port_value,
                  input code_value, input byte_position, output ready);
endinterface

// ----- rtl/bcrm_front.sv -----
// bcrm_front: byte decoder. Tracks phase, halt and position, builds commands.
// Depends on bcrm_pkg and bcrm_in_if.
module bcrm_front #(
  parameter longint unsigned PROGRAM_BYTES = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bcrm_in_if.sink         byte_i,
  output bcrm_pkg::cmd_t  cmd_o,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i
);
  import bcrm_pkg::*;

  localparam logic [PosW-1:0] PosLimit =
      (PROGRAM_BYTES < 64'd65535) ? PosW'(PROGRAM_BYTES) : {PosW{1'b1}};

  logic            halted_q, halted_d;
  logic [3:0]      phase_q, phase_d;
  opc_e            opc_q, opc_d;
  logic [7:0]      fop_q, fop_d;
  logic [DataW-1:0] imm_q, imm_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            fire;
  logic [3:0]      lane;
  logic [7:0]      b;

  assign byte_i.ready = cmd_ready_i;
  assign fire = byte_i.valid && byte_i.ready;
  assign b    = byte_i.code_byte;
  // immediate byte lane; only used mid-MOV, where the phase is not reset
  assign lane = phase_q - PhSecond;

  always_comb begin
    halted_d    = halted_q;
    phase_d     = phase_q;
    opc_d       = opc_q;
    fop_d       = fop_q;
    imm_d       = imm_q;
    pos_d       = pos_q;
    cmd_o       = '0;
    cmd_valid_o = 1'b0;
    if (fire) begin
      if (byte_i.first_byte) begin
        halted_d = 1'b0;
        phase_d  = PhOpcode;
        imm_d    = '0;
        pos_d    = '0;
      end
      if (!halted_d) begin
        if (pos_d < PosLimit) pos_d = pos_d + PosW'(1);
        if (phase_d == PhOpcode) begin
          case (b)
            OpHalt: begin
              halted_d    = 1'b1;
              cmd_o.kind  = CMD_HALT;
              cmd_o.pos   = pos_d;
              cmd_valid_o = 1'b1;
            end
            OpMov: begin opc_d = OPC_MOV; phase_d = PhOperand; imm_d = '0; end
            OpAdd: begin opc_d = OPC_ADD; phase_d = PhOperand; imm_d = '0; end
            OpOut: begin opc_d = OPC_OUT; phase_d = PhOperand; imm_d = '0; end
            OpSys: begin opc_d = OPC_SYS; phase_d = PhOperand; imm_d = '0; end
            default: begin
              halted_d    = 1'b1;
              cmd_o.kind  = CMD_UNK;
              cmd_o.code  = b;
              cmd_o.pos   = pos_d;
              cmd_valid_o = 1'b1;
            end
          endcase
        end else if (phase_d == PhOperand) begin
          case (opc_q)
            OPC_SYS: begin
              cmd_o.kind  = CMD_SYS;
              cmd_o.code  = b;
              cmd_valid_o = 1'b1;
              phase_d     = PhOpcode;
            end
            OPC_MOV, OPC_ADD, OPC_OUT: begin
              fop_d   = b;
              phase_d = PhSecond;
            end
            default: phase_d = PhOpcode;
          endcase
        end else if (opc_q == OPC_MOV && phase_d <= PhImmLast) begin
          imm_d[{lane[2:0], 3'b000} +: 8] = imm_d[{lane[2:0], 3'b000} +: 8] | b;
          if (phase_d == PhImmLast) begin
            cmd_o.kind  = CMD_MOV;
            cmd_o.ra    = fop_q[RegAddrW-1:0];
            cmd_o.imm   = imm_d;
            cmd_valid_o = 1'b1;
            phase_d     = PhOpcode;
          end else begin
            phase_d = phase_d + 4'd1;
          end
        end else if (opc_q == OPC_ADD && phase_d == PhSecond) begin
          cmd_o.kind  = CMD_ADD;
          cmd_o.ra    = fop_q[RegAddrW-1:0];
          cmd_o.rb    = b[RegAddrW-1:0];
          cmd_valid_o = 1'b1;
          phase_d     = PhOpcode;
        end else if (opc_q == OPC_OUT && phase_d == PhSecond) begin
          cmd_o.kind  = CMD_OUT;
          cmd_o.code  = fop_q;
          cmd_o.rb    = b[RegAddrW-1:0];
          cmd_valid_o = 1'b1;
          phase_d     = PhOpcode;
        end else begin
          phase_d = PhOpcode;
        end
        // truncated instruction: drop it
        if (byte_i.last_byte && phase_d != PhOpcode) begin
          phase_d = PhOpcode;
          imm_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      phase_q  <= PhOpcode;
      opc_q    <= OPC_NONE;
      fop_q    <= '0;
      imm_q    <= '0;
      pos_q    <= '0;
    end else begin
      halted_q <= halted_d;
      phase_q  <= phase_d;
      opc_q    <= opc_d;
      fop_q    <= fop_d;
      imm_q    <= imm_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// ----- rtl/bcrm_queue.sv -----
// bcrm_queue: short command FIFO between decoder and execute unit.
// Depends on bcrm_pkg.
module bcrm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bcrm_pkg::cmd_t push_cmd_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output bcrm_pkg::cmd_t pop_cmd_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);
  import bcrm_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop)      count_q <= count_q + CntW'(1);
      else if (pop && !push) count_q <= count_q - CntW'(1);
    end
  end

endmodule

// ----- rtl/bcrm_back.sv -----
// bcrm_back: execute unit. Register file memory, one execute stage with
// write forwarding, and the event output register. Depends on bcrm_pkg, bcrm_out_if.
module bcrm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bcrm_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  bcrm_out_if.source     event_o
);
  import bcrm_pkg::*;

  logic [DataW-1:0]    mem [NumRegs];
  logic [NumRegs-1:0]  written_q;

  cmd_t                e_cmd_q;
  logic                e_valid_q;
  logic [DataW-1:0]    rd_a_q, rd_b_q;
  logic                va_q, vb_q;

  logic                wb_en_q;
  logic [RegAddrW-1:0] wb_addr_q;
  logic [DataW-1:0]    wb_data_q;

  logic                out_valid_q;
  logic [1:0]          out_kind_q;
  logic [7:0]          out_port_q, out_code_q;
  logic [DataW-1:0]    out_value_q;
  logic [PosW-1:0]     out_pos_q;

  logic                has_result, slot_free, e_fire, load, we;
  logic [DataW-1:0]    opa, opb, wd;

  // register value: last write wins over the registered read
  function automatic logic [DataW-1:0] pick(input logic fwd, input logic [DataW-1:0] fdata,
                                            input logic valid, input logic [DataW-1:0] rdata);
    logic [DataW-1:0] r;
    r = fwd ? fdata : (valid ? rdata : '0);
    return r;
  endfunction

  assign opa = pick(wb_en_q && wb_addr_q == e_cmd_q.ra, wb_data_q, va_q, rd_a_q);
  assign opb = pick(wb_en_q && wb_addr_q == e_cmd_q.rb, wb_data_q, vb_q, rd_b_q);

  assign has_result  = !(e_cmd_q.kind == CMD_MOV || e_cmd_q.kind == CMD_ADD);
  assign slot_free   = !out_valid_q || event_o.ready;
  assign e_fire      = e_valid_q && (!has_result || slot_free);
  assign cmd_ready_o = !e_valid_q || e_fire;
  assign load        = cmd_valid_i && cmd_ready_o;
  assign we          = e_fire && !has_result;
  assign wd          = (e_cmd_q.kind == CMD_MOV) ? e_cmd_q.imm : opa + opb;

  always_ff @(posedge clk_i) begin
    if (load) begin
      e_cmd_q <= cmd_i;
      rd_a_q  <= mem[cmd_i.ra];
      rd_b_q  <= mem[cmd_i.rb];
      va_q    <= written_q[cmd_i.ra];
      vb_q    <= written_q[cmd_i.rb];
    end
    if (we) mem[e_cmd_q.ra] <= wd;
    if (we) begin
      wb_addr_q <= e_cmd_q.ra;
      wb_data_q <= wd;
    end
    if (e_fire && has_result) begin
      out_kind_q  <= EvOut;
      out_port_q  <= '0;
      out_value_q <= '0;
      out_code_q  <= '0;
      out_pos_q   <= '0;
      case (e_cmd_q.kind)
        CMD_OUT: begin
          out_port_q  <= e_cmd_q.code;
          out_value_q <= opb;
        end
        CMD_SYS: begin
          out_kind_q <= EvSys;
          out_code_q <= e_cmd_q.code;
        end
        CMD_HALT: begin
          out_kind_q <= EvHalt;
          out_pos_q  <= e_cmd_q.pos;
        end
        default: begin
          out_kind_q <= EvUnknown;
          out_code_q <= e_cmd_q.code;
          out_pos_q  <= e_cmd_q.pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      written_q   <= '0;
      wb_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load)        e_valid_q <= 1'b1;
      else if (e_fire) e_valid_q <= 1'b0;
      if (we) begin
        written_q[e_cmd_q.ra] <= 1'b1;
        wb_en_q               <= 1'b1;
      end
      if (e_fire && has_result) out_valid_q <= 1'b1;
      else if (event_o.ready)   out_valid_q <= 1'b0;
    end
  end

  assign event_o.valid         = out_valid_q;
  assign event_o.event_kind    = out_kind_q;
  assign event_o.port_number   = out_port_q;
  assign event_o.port_value    = out_value_q;
  assign event_o.code_value    = out_code_q;
  assign event_o.byte_position = out_pos_q;

  // stalled command stays in the execute stage
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
      e_valid_q && !e_fire |=> e_valid_q && $stable(e_cmd_q.kind))
    else $error("execute stage dropped a stalled command");

  // only register-writing commands retire without a slot
  a_result_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
      e_fire && has_result |-> slot_free)
    else $error("event issued while output register busy");

  // forwarding register tracks the last write
  a_fwd_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
      we |=> wb_en_q && wb_addr_q == $past(e_cmd_q.ra) && wb_data_q == $past(wd))
    else $error("forwarding register out of step with write");

  // a written register is marked valid
  a_written_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
      we |=> written_q[$past(e_cmd_q.ra)])
    else $error("register write not marked");

endmodule

// ----- rtl/bytecode_register_machine_top.sv -----
// bytecode_register_machine_top: top level of the byte-stream register machine.
// Depends on bcrm_pkg, bcrm_if, bcrm_front, bcrm_queue, bcrm_back.
//
// Program bytes enter on byte_i, one byte per cycle while byte_i.ready is high;
// events (port output, syscall, halt, unknown opcode) leave on event_o. The
// decoder takes a byte in every cycle in which the four-entry command queue has
// room; the byte that completes a command writes it into the queue, from which
// it is loaded into the execute stage, and its event is then presented in the
// output register; a busy execute stage or output register can hold it at each
// step. The execute stage retires one command per cycle, paced by the output
// register: a stalled consumer fills the queue and then holds byte_i.ready low.
// The sixteen 64-bit registers live in a memory with one write and two
// registered read ports; per-register written bits, cleared at reset, make
// every register read as zero until first written, so no clearing pass is
// needed. A write is forwarded to the command directly behind it.
module bytecode_register_machine_top #(
  parameter longint unsigned PROGRAM_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcrm_in_if.sink    byte_i,
  bcrm_out_if.source event_o
);
  import bcrm_pkg::*;

  // decoder to queue
  cmd_t push_cmd;
  logic push_valid, push_ready;
  // queue to execute
  cmd_t pop_cmd;
  logic pop_valid, pop_ready;

  bcrm_front #(
    .PROGRAM_BYTES(PROGRAM_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cmd_o       (push_cmd),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready)
  );

  bcrm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (push_cmd),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_cmd_o    (pop_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  bcrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .event_o     (event_o)
  );

endmodule
